// ----- hdl/cvr_pkg.sv -----
// shared widths, types and register codes of the collision velocity response block
`default_nettype none

package cvr_pkg;

  localparam int VW   = 32;   // velocity, Q16.16
  localparam int NW   = 16;   // normal, Q2.14
  localparam int MW   = 32;   // mass
  localparam int CW   = 17;   // coefficient register, Q1.16
  localparam int KW   = 18;   // one plus coefficient, and mass weight
  localparam int PRW  = 48;   // velocity times normal
  localparam int DW   = 50;   // dot product
  localparam int PW   = 37;   // projection length
  localparam int LOW  = 18;   // low slice of the projection length
  localparam int HPW  = 35;   // projection partial product
  localparam int XW   = 40;   // normal and tangential parts
  localparam int SPL  = 20;   // low slice of a part for scaling
  localparam int TW   = 44;   // scaled part
  localparam int RW   = 46;   // combined result before clamp
  localparam int NUMW = 51;   // weight dividend
  localparam int DENW = 33;   // mass sum
  localparam int QW   = 18;   // weight quotient bits

  localparam int NSTG      = 24;
  localparam int PROJ_STG  = 6;
  localparam int DIV_FIRST = 3;
  localparam int DIV_LAST  = DIV_FIRST + QW - 1;
  localparam int RESP_STG  = 4;

  localparam logic [KW-1:0] ONE_Q16 = KW'(65536);
  localparam logic [CW-1:0] RESTITUTION_RST  = CW'(32768);
  localparam logic [CW-1:0] TANGENT_KEEP_RST = CW'(58982);

  // register index, taken from paddr bit 2
  localparam logic REG_RESTITUTION  = 1'b0;
  localparam logic REG_TANGENT_KEEP = 1'b1;

  localparam logic [1:0] FROZEN_NONE = 2'b00;
  localparam int         FROZEN_A_BIT = 0;

  typedef logic signed [VW-1:0] vel_t;
  typedef logic signed [NW-1:0] nrm_t;
  typedef logic signed [XW-1:0] xw_t;
  typedef vel_t [2:0] vel3_t;
  typedef nrm_t [2:0] nrm3_t;
  typedef xw_t  [2:0] xw3_t;

  typedef struct packed {
    vel3_t      va;
    vel3_t      vb;
    logic [1:0] mask;
  } car_t;

  typedef struct packed {
    vel3_t      va;
    vel3_t      vb;
    xw3_t       van;
    xw3_t       vbn;
    xw3_t       vat;
    xw3_t       vbt;
    xw3_t       dvn;
    xw3_t       dan;
    logic [1:0] mask;
    logic       sep;
    logic       dz;
  } mid_t;

endpackage

`default_nettype wire

// ----- hdl/collision_velocity_response.sv -----
// top level of the collision velocity response pipeline with its register port
//
//  channel | direction | handshake               | payload
//  in      | request   | in_valid_i / in_ready_o | velocities, normal, masses, frozen mask
//  out     | result    | out_valid_o/out_ready_i | new velocities, separating, saturated
//  cfg     | apb write | psel penable pwrite     | restitution (0x0), tangent_keep (0x4)
//
//  one request per cycle sustained while out_ready_i does not stall the out channel
//  the pipeline depth is set by the 18-stage weight divider and the stages around it
//  each stage holds only while its successor is full, so bubbles close up
//  reset clears all stage valid bits and loads the coefficient defaults
`default_nettype none

module collision_velocity_response (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [cvr_pkg::VW-1:0]   vel_a_x_i,
  input  logic signed [cvr_pkg::VW-1:0]   vel_a_y_i,
  input  logic signed [cvr_pkg::VW-1:0]   vel_a_z_i,
  input  logic signed [cvr_pkg::VW-1:0]   vel_b_x_i,
  input  logic signed [cvr_pkg::VW-1:0]   vel_b_y_i,
  input  logic signed [cvr_pkg::VW-1:0]   vel_b_z_i,
  input  logic signed [cvr_pkg::NW-1:0]   normal_x_i,
  input  logic signed [cvr_pkg::NW-1:0]   normal_y_i,
  input  logic signed [cvr_pkg::NW-1:0]   normal_z_i,
  input  logic [cvr_pkg::MW-1:0]          mass_a_i,
  input  logic [cvr_pkg::MW-1:0]          mass_b_i,
  input  logic [1:0]                      frozen_mask_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [cvr_pkg::VW-1:0]   new_vel_a_x_o,
  output logic signed [cvr_pkg::VW-1:0]   new_vel_a_y_o,
  output logic signed [cvr_pkg::VW-1:0]   new_vel_a_z_o,
  output logic signed [cvr_pkg::VW-1:0]   new_vel_b_x_o,
  output logic signed [cvr_pkg::VW-1:0]   new_vel_b_y_o,
  output logic signed [cvr_pkg::VW-1:0]   new_vel_b_z_o,
  output logic                            separating_o,
  output logic                            saturated_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [2:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import cvr_pkg::*;

  logic [CW-1:0]   e_q, f_q;
  logic [KW-1:0]   k, kh;
  logic [KW:0]     k_inc;
  logic            wr;

  logic [NSTG:1]   v_q;
  logic [NSTG:1]   en;

  vel3_t           va, vb, nva, nvb;
  nrm3_t           nrm;
  logic [NUMW-1:0] num_a, num_b;
  logic [DENW-1:0] den;
  logic [QW-1:0]   qa, qb;
  mid_t            mid6;
  mid_t            dly_q [PROJ_STG+1:DIV_LAST];

  // register port
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TANGENT_KEEP) ? 32'(f_q) : 32'(e_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_q <= RESTITUTION_RST;
      f_q <= TANGENT_KEEP_RST;
    end else if (wr) begin
      if (paddr[2] == REG_RESTITUTION) begin
        e_q <= pwdata[CW-1:0];
      end else begin
        f_q <= pwdata[CW-1:0];
      end
    end
  end

  assign k     = KW'(e_q) + ONE_Q16;
  assign k_inc = (KW+1)'(k) + (KW+1)'(1);
  assign kh    = k_inc[KW:1];

  // stage valids and enables
  always_comb begin
    en[NSTG] = !v_q[NSTG] || out_ready_i;
    for (int s = NSTG - 1; s >= 1; s--) begin
      en[s] = !v_q[s] || en[s+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) begin
        v_q[1] <= in_valid_i;
      end
      for (int s = 2; s <= NSTG; s++) begin
        if (en[s]) begin
          v_q[s] <= v_q[s-1];
        end
      end
    end
  end

  assign in_ready_o  = en[1];
  assign out_valid_o = v_q[NSTG];

  assign va  = {vel_a_z_i, vel_a_y_i, vel_a_x_i};
  assign vb  = {vel_b_z_i, vel_b_y_i, vel_b_x_i};
  assign nrm = {normal_z_i, normal_y_i, normal_x_i};

  cvr_proj u_proj (
    .clk_i    (clk_i),
    .en_i     (en[PROJ_STG:1]),
    .va_i     (va),
    .vb_i     (vb),
    .n_i      (nrm),
    .mass_a_i (mass_a_i),
    .mass_b_i (mass_b_i),
    .mask_i   (frozen_mask_i),
    .k_i      (k),
    .num_a_o  (num_a),
    .num_b_o  (num_b),
    .den_o    (den),
    .mid_o    (mid6)
  );

  cvr_div u_div_a (
    .clk_i (clk_i),
    .en_i  (en[DIV_LAST:DIV_FIRST]),
    .num_i (num_a),
    .den_i (den),
    .quo_o (qa)
  );

  cvr_div u_div_b (
    .clk_i (clk_i),
    .en_i  (en[DIV_LAST:DIV_FIRST]),
    .num_i (num_b),
    .den_i (den),
    .quo_o (qb)
  );

  // delay of the split parts until the weights are ready
  for (genvar s = PROJ_STG + 1; s <= DIV_LAST; s++) begin : g_dly
    if (s == PROJ_STG + 1) begin : g_first
      always_ff @(posedge clk_i) begin
        if (en[s]) begin
          dly_q[s] <= mid6;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        if (en[s]) begin
          dly_q[s] <= dly_q[s-1];
        end
      end
    end
  end

  cvr_resp u_resp (
    .clk_i  (clk_i),
    .en_i   (en[NSTG:DIV_LAST+1]),
    .mid_i  (dly_q[DIV_LAST]),
    .qa_i   (qa),
    .qb_i   (qb),
    .kh_i   (kh),
    .e_i    (e_q),
    .f_i    (f_q),
    .nva_o  (nva),
    .nvb_o  (nvb),
    .sep_o  (separating_o),
    .sat_o  (saturated_o)
  );

  assign new_vel_a_x_o = nva[0];
  assign new_vel_a_y_o = nva[1];
  assign new_vel_a_z_o = nva[2];
  assign new_vel_b_x_o = nvb[0];
  assign new_vel_b_y_o = nvb[1];
  assign new_vel_b_z_o = nvb[2];

endmodule

`default_nettype wire

// ----- hdl/cvr_proj.sv -----
// dot products, projection onto the normal and split into normal and tangential parts
`default_nettype none

module cvr_proj (
  input  logic                        clk_i,
  input  logic [cvr_pkg::PROJ_STG-1:0] en_i,
  input  cvr_pkg::vel3_t              va_i,
  input  cvr_pkg::vel3_t              vb_i,
  input  cvr_pkg::nrm3_t              n_i,
  input  logic [cvr_pkg::MW-1:0]      mass_a_i,
  input  logic [cvr_pkg::MW-1:0]      mass_b_i,
  input  logic [1:0]                  mask_i,
  input  logic [cvr_pkg::KW-1:0]      k_i,
  output logic [cvr_pkg::NUMW-1:0]    num_a_o,
  output logic [cvr_pkg::NUMW-1:0]    num_b_o,
  output logic [cvr_pkg::DENW-1:0]    den_o,
  output cvr_pkg::mid_t               mid_o
);
  import cvr_pkg::*;

  car_t                    car1_q, car2_q, car3_q, car4_q, car5_q;
  nrm3_t                   n1_q, n2_q, n3_q;
  logic signed [PRW-1:0]   pra1_q [3];
  logic signed [PRW-1:0]   prb1_q [3];
  logic [MW+KW-1:0]        na1_q, nb1_q;
  logic [DENW-1:0]         den1_q, den2_q;
  logic signed [DW-1:0]    da2_q, db2_q;
  logic [NUMW-1:0]         num_a2_q, num_b2_q;
  logic                    sep2_q, sep3_q, sep4_q, sep5_q;
  logic                    dz2_q, dz3_q, dz4_q, dz5_q;
  logic signed [PW-1:0]    pa3_q, pb3_q;
  logic signed [HPW-1:0]   loa4_q [3];
  logic signed [HPW-1:0]   hia4_q [3];
  logic signed [HPW-1:0]   lob4_q [3];
  logic signed [HPW-1:0]   hib4_q [3];
  xw_t                     van5_q [3];
  xw_t                     vbn5_q [3];
  mid_t                    mid6_q;

  logic signed [DW:0]      pa_t, pb_t;
  logic signed [XW+13:0]   vana_t [3];
  logic signed [XW+13:0]   vbna_t [3];

  // stage 1: products along the normal, weight dividends
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      car1_q <= '{va: va_i, vb: vb_i, mask: mask_i};
      n1_q   <= n_i;
      for (int i = 0; i < 3; i++) begin
        pra1_q[i] <= $signed(va_i[i]) * $signed(n_i[i]);
        prb1_q[i] <= $signed(vb_i[i]) * $signed(n_i[i]);
      end
      na1_q  <= mass_a_i * k_i;
      nb1_q  <= mass_b_i * k_i;
      den1_q <= DENW'(mass_a_i) + DENW'(mass_b_i);
    end
  end

  // stage 2: dot products, separation test, rounded dividends
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      car2_q   <= car1_q;
      n2_q     <= n1_q;
      da2_q    <= DW'(pra1_q[0]) + DW'(pra1_q[1]) + DW'(pra1_q[2]);
      db2_q    <= DW'(prb1_q[0]) + DW'(prb1_q[1]) + DW'(prb1_q[2]);
      sep2_q   <= (DW'(pra1_q[0]) + DW'(pra1_q[1]) + DW'(pra1_q[2]))
                > (DW'(prb1_q[0]) + DW'(prb1_q[1]) + DW'(prb1_q[2]));
      num_a2_q <= NUMW'(na1_q) + NUMW'(den1_q >> 1);
      num_b2_q <= NUMW'(nb1_q) + NUMW'(den1_q >> 1);
      den2_q   <= den1_q;
      dz2_q    <= (den1_q == '0);
    end
  end

  assign pa_t = (DW+1)'(da2_q) + (DW+1)'(8192);
  assign pb_t = (DW+1)'(db2_q) + (DW+1)'(8192);

  // stage 3: projection lengths
  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      car3_q <= car2_q;
      n3_q   <= n2_q;
      sep3_q <= sep2_q;
      dz3_q  <= dz2_q;
      pa3_q  <= pa_t[DW:14];
      pb3_q  <= pb_t[DW:14];
    end
  end

  // stage 4: partial products of normal times length
  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      car4_q <= car3_q;
      sep4_q <= sep3_q;
      dz4_q  <= dz3_q;
      for (int i = 0; i < 3; i++) begin
        loa4_q[i] <= $signed(n3_q[i]) * $signed({1'b0, pa3_q[LOW-1:0]});
        hia4_q[i] <= $signed(n3_q[i]) * $signed(pa3_q[PW-1:LOW]);
        lob4_q[i] <= $signed(n3_q[i]) * $signed({1'b0, pb3_q[LOW-1:0]});
        hib4_q[i] <= $signed(n3_q[i]) * $signed(pb3_q[PW-1:LOW]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vana_t[i] = (XW+14)'($signed({hia4_q[i], {LOW{1'b0}}}) + (HPW+LOW)'(loa4_q[i]))
                + (XW+14)'(8192);
      vbna_t[i] = (XW+14)'($signed({hib4_q[i], {LOW{1'b0}}}) + (HPW+LOW)'(lob4_q[i]))
                + (XW+14)'(8192);
    end
  end

  // stage 5: normal parts
  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      car5_q <= car4_q;
      sep5_q <= sep4_q;
      dz5_q  <= dz4_q;
      for (int i = 0; i < 3; i++) begin
        van5_q[i] <= vana_t[i][XW+13:14];
        vbn5_q[i] <= vbna_t[i][XW+13:14];
      end
    end
  end

  // stage 6: tangential parts and normal differences
  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      mid6_q.va   <= car5_q.va;
      mid6_q.vb   <= car5_q.vb;
      mid6_q.mask <= car5_q.mask;
      mid6_q.sep  <= sep5_q;
      mid6_q.dz   <= dz5_q;
      for (int i = 0; i < 3; i++) begin
        mid6_q.van[i] <= van5_q[i];
        mid6_q.vbn[i] <= vbn5_q[i];
        mid6_q.vat[i] <= XW'($signed(car5_q.va[i])) - van5_q[i];
        mid6_q.vbt[i] <= XW'($signed(car5_q.vb[i])) - vbn5_q[i];
        mid6_q.dvn[i] <= vbn5_q[i] - van5_q[i];
        mid6_q.dan[i] <= van5_q[i] - vbn5_q[i];
      end
    end
  end

  assign num_a_o = num_a2_q;
  assign num_b_o = num_b2_q;
  assign den_o   = den2_q;
  assign mid_o   = mid6_q;

endmodule

`default_nettype wire

// ----- hdl/cvr_div.sv -----
// pipelined restoring divider, one quotient bit per stage, for the mass weights
`default_nettype none

module cvr_div (
  input  logic                      clk_i,
  input  logic [cvr_pkg::QW-1:0]    en_i,
  input  logic [cvr_pkg::NUMW-1:0]  num_i,
  input  logic [cvr_pkg::DENW-1:0]  den_i,
  output logic [cvr_pkg::QW-1:0]    quo_o
);
  import cvr_pkg::*;

  logic [NUMW-1:0] rem_s [QW];
  logic [DENW-1:0] den_s [QW];
  logic [QW-1:0]   quo_s [QW];
  logic [NUMW-1:0] rem_q [QW-1];
  logic [DENW-1:0] den_q [QW-1];
  logic [QW-1:0]   quo_q [QW];

  for (genvar j = 0; j < QW; j++) begin : g_stg
    localparam int B = QW - 1 - j;
    logic [NUMW-1:0] sh;
    logic            ge;

    if (j == 0) begin : g_first
      assign rem_s[j] = num_i;
      assign den_s[j] = den_i;
      assign quo_s[j] = '0;
    end else begin : g_next
      assign rem_s[j] = rem_q[j-1];
      assign den_s[j] = den_q[j-1];
      assign quo_s[j] = quo_q[j-1];
    end

    assign sh = NUMW'(den_s[j]) << B;
    assign ge = (rem_s[j] >= sh);

    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        quo_q[j] <= {quo_s[j][QW-2:0], ge};
      end
    end

    if (j < QW - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i[j]) begin
          rem_q[j] <= ge ? (rem_s[j] - sh) : rem_s[j];
          den_q[j] <= den_s[j];
        end
      end
    end
  end

  assign quo_o = quo_q[QW-1];

endmodule

`default_nettype wire

// ----- hdl/cvr_resp.sv -----
// restitution and friction scaling, mode select and output clamp
`default_nettype none

module cvr_resp (
  input  logic                        clk_i,
  input  logic [cvr_pkg::RESP_STG-1:0] en_i,
  input  cvr_pkg::mid_t               mid_i,
  input  logic [cvr_pkg::QW-1:0]      qa_i,
  input  logic [cvr_pkg::QW-1:0]      qb_i,
  input  logic [cvr_pkg::KW-1:0]      kh_i,
  input  logic [cvr_pkg::CW-1:0]      e_i,
  input  logic [cvr_pkg::CW-1:0]      f_i,
  output cvr_pkg::vel3_t              nva_o,
  output cvr_pkg::vel3_t              nvb_o,
  output logic                        sep_o,
  output logic                        sat_o
);
  import cvr_pkg::*;

  typedef struct packed {
    logic signed [XW-1:0]   lo;
    logic signed [XW-2:0]   hi;
  } pp_t;

  typedef logic signed [TW-1:0] term_t;
  typedef logic signed [RW-1:0] res_t;

  function automatic pp_t split_mul(logic [QW-1:0] c, xw_t x);
    pp_t p;
    p.lo = $signed({1'b0, c}) * $signed({1'b0, x[SPL-1:0]});
    p.hi = $signed({1'b0, c}) * $signed(x[XW-1:SPL]);
    return p;
  endfunction

  function automatic term_t join_rnd(pp_t p);
    logic signed [XW+SPL-2:0] s;
    logic signed [XW+SPL-1:0] t;
    s = $signed({p.hi, {SPL{1'b0}}}) + (XW+SPL-1)'(p.lo);
    t = (XW+SPL)'(s) + (XW+SPL)'(32768);
    return t[XW+SPL-1:16];
  endfunction

  mid_t        mid1_q, mid2_q;
  pp_t         fa1_q [3];
  pp_t         ta1_q [3];
  pp_t         fb1_q [3];
  pp_t         tb1_q [3];
  term_t       fa2_q [3];
  term_t       ta2_q [3];
  term_t       fb2_q [3];
  term_t       tb2_q [3];
  res_t        ra3_q [3];
  res_t        rb3_q [3];
  logic        sep3_q, sep4_q, sat4_q;
  vel3_t       nva4_q, nvb4_q;

  logic        both;
  logic [QW-1:0] wa, wb, ca, cb;
  res_t        ra_d [3];
  res_t        rb_d [3];
  logic        sat_d;
  vel3_t       nva_d, nvb_d;

  assign both = (mid_i.mask == FROZEN_NONE);
  assign wa   = mid_i.dz ? kh_i : qa_i;
  assign wb   = mid_i.dz ? kh_i : qb_i;
  assign ca   = both ? wb : QW'(e_i);
  assign cb   = both ? wa : QW'(e_i);

  // stage 1: partial products
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      mid1_q <= mid_i;
      for (int i = 0; i < 3; i++) begin
        fa1_q[i] <= split_mul(QW'(f_i), mid_i.vat[i]);
        fb1_q[i] <= split_mul(QW'(f_i), mid_i.vbt[i]);
        ta1_q[i] <= split_mul(ca, both ? mid_i.dvn[i] : mid_i.van[i]);
        tb1_q[i] <= split_mul(cb, both ? mid_i.dan[i] : mid_i.vbn[i]);
      end
    end
  end

  // stage 2: rounded scaled parts
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      mid2_q <= mid1_q;
      for (int i = 0; i < 3; i++) begin
        fa2_q[i] <= join_rnd(fa1_q[i]);
        ta2_q[i] <= join_rnd(ta1_q[i]);
        fb2_q[i] <= join_rnd(fb1_q[i]);
        tb2_q[i] <= join_rnd(tb1_q[i]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ra_d[i] = RW'($signed(mid2_q.va[i]));
      rb_d[i] = RW'($signed(mid2_q.vb[i]));
      if (!mid2_q.sep) begin
        if (mid2_q.mask == FROZEN_NONE) begin
          ra_d[i] = RW'(mid2_q.van[i]) + RW'(ta2_q[i]) + RW'(fa2_q[i]);
          rb_d[i] = RW'(mid2_q.vbn[i]) + RW'(tb2_q[i]) + RW'(fb2_q[i]);
        end else if (mid2_q.mask[FROZEN_A_BIT]) begin
          rb_d[i] = RW'(fb2_q[i]) - RW'(tb2_q[i]);
        end else begin
          ra_d[i] = RW'(fa2_q[i]) - RW'(ta2_q[i]);
        end
      end
    end
  end

  // stage 3: combined results
  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      sep3_q <= mid2_q.sep;
      for (int i = 0; i < 3; i++) begin
        ra3_q[i] <= ra_d[i];
        rb3_q[i] <= rb_d[i];
      end
    end
  end

  always_comb begin
    sat_d = 1'b0;
    for (int i = 0; i < 3; i++) begin
      nva_d[i] = ra3_q[i][VW-1:0];
      nvb_d[i] = rb3_q[i][VW-1:0];
      if (ra3_q[i] > RW'(32'sh7fffffff)) begin
        nva_d[i] = 32'sh7fffffff;
        sat_d    = 1'b1;
      end else if (ra3_q[i] < RW'(32'sh80000000)) begin
        nva_d[i] = 32'sh80000000;
        sat_d    = 1'b1;
      end
      if (rb3_q[i] > RW'(32'sh7fffffff)) begin
        nvb_d[i] = 32'sh7fffffff;
        sat_d    = 1'b1;
      end else if (rb3_q[i] < RW'(32'sh80000000)) begin
        nvb_d[i] = 32'sh80000000;
        sat_d    = 1'b1;
      end
    end
  end

  // stage 4: clamp into the output register
  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      nva4_q <= nva_d;
      nvb4_q <= nvb_d;
      sep4_q <= sep3_q;
      sat4_q <= sat_d;
    end
  end

  assign nva_o = nva4_q;
  assign nvb_o = nvb4_q;
  assign sep_o = sep4_q;
  assign sat_o = sat4_q;

endmodule

`default_nettype wire

// ----- hdl/cvr_chk.sv -----
// port-level checks of the collision velocity response block and their binding
`default_nettype none

module cvr_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] new_vel_a_x_o,
  input logic [31:0] new_vel_b_z_o,
  input logic        separating_o,
  input logic        saturated_o,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  a_sep_no_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && separating_o |-> !saturated_o)
    else $error("separating result flagged as clamped");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(new_vel_a_x_o)
      && $stable(new_vel_b_z_o) && $stable(separating_o) && $stable(saturated_o))
    else $error("stalled result changed");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("pready low");

  a_cfg_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && !paddr[2]) ##1 !paddr[2]
      |-> prdata == {15'b0, $past(pwdata[16:0])})
    else $error("restitution readback mismatch");

endmodule

bind collision_velocity_response cvr_chk u_cvr_chk (.*);

`default_nettype wire

// ----- bench/collision_velocity_response_tb.sv -----
// self-checking testbench of the collision velocity response pipeline
`default_nettype none

module collision_velocity_response_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cvr_pkg::*;

  typedef struct {
    vel3_t       va;
    vel3_t       vb;
    nrm3_t       n;
    logic [31:0] ma;
    logic [31:0] mb;
    logic [1:0]  frz;
  } contact_t;

  typedef struct {
    vel3_t va;
    vel3_t vb;
    logic  sep;
    logic  sat;
  } response_t;

  typedef struct {
    contact_t c;
    bit       pass_thru;
  } row_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  vel3_t va_d, vb_d, va_q, vb_q;
  nrm3_t n_d;
  logic [31:0] ma_d, mb_d;
  logic [1:0] frz_d;
  logic sep_q, sat_q;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  collision_velocity_response dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .vel_a_x_i(va_d[0]), .vel_a_y_i(va_d[1]), .vel_a_z_i(va_d[2]),
    .vel_b_x_i(vb_d[0]), .vel_b_y_i(vb_d[1]), .vel_b_z_i(vb_d[2]),
    .normal_x_i(n_d[0]), .normal_y_i(n_d[1]), .normal_z_i(n_d[2]),
    .mass_a_i(ma_d), .mass_b_i(mb_d), .frozen_mask_i(frz_d),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .new_vel_a_x_o(va_q[0]), .new_vel_a_y_o(va_q[1]), .new_vel_a_z_o(va_q[2]),
    .new_vel_b_x_o(vb_q[0]), .new_vel_b_y_o(vb_q[1]), .new_vel_b_z_o(vb_q[2]),
    .separating_o(sep_q), .saturated_o(sat_q),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  response_t pending_responses[$];
  longint coef_e, coef_f;
  int errors, n_req, n_resp, n_sep, n_sat, cycles;
  int tx_max, rx_max, rx_hold;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("timeout at %0t", $realtime);
      $display("FAIL");
      $finish;
    end
  end

  function automatic longint rnd_shift(longint x, int k);
    return (x + (longint'(1) <<< (k - 1))) >>> k;
  endfunction

  function automatic vel_t clamp32(longint x, ref logic sat);
    if (x > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7fffffff;
    end
    if (x < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return vel_t'(x);
  endfunction

  function automatic response_t resolve_contact(contact_t c);
    response_t r;
    longint va[3], vb[3], n[3], van[3], vbn[3], vat[3], vbt[3], ra[3], rb[3];
    longint da, db, pa, pb, wa, wb, ma, mb, den, k;
    logic sat;
    da = 0;
    db = 0;
    sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      va[i] = c.va[i];
      vb[i] = c.vb[i];
      n[i] = c.n[i];
      da += va[i] * n[i];
      db += vb[i] * n[i];
    end
    r.va = c.va;
    r.vb = c.vb;
    r.sep = 1'b0;
    r.sat = 1'b0;
    if (da - db > 0) begin
      r.sep = 1'b1;
      return r;
    end
    pa = rnd_shift(da, 14);
    pb = rnd_shift(db, 14);
    for (int i = 0; i < 3; i++) begin
      van[i] = rnd_shift(n[i] * pa, 14);
      vbn[i] = rnd_shift(n[i] * pb, 14);
      vat[i] = va[i] - van[i];
      vbt[i] = vb[i] - vbn[i];
      ra[i] = va[i];
      rb[i] = vb[i];
    end
    if (c.frz == FROZEN_NONE) begin
      ma = longint'(c.ma);
      mb = longint'(c.mb);
      den = ma + mb;
      k = 65536 + coef_e;
      if (den == 0) begin
        wa = (k + 1) / 2;
        wb = wa;
      end else begin
        wa = (ma * k + den / 2) / den;
        wb = (mb * k + den / 2) / den;
      end
      for (int i = 0; i < 3; i++) begin
        ra[i] = van[i] + rnd_shift(wb * (vbn[i] - van[i]), 16) + rnd_shift(coef_f * vat[i], 16);
        rb[i] = vbn[i] + rnd_shift(wa * (van[i] - vbn[i]), 16) + rnd_shift(coef_f * vbt[i], 16);
      end
    end else if (c.frz[FROZEN_A_BIT]) begin
      for (int i = 0; i < 3; i++)
        rb[i] = rnd_shift(coef_f * vbt[i], 16) - rnd_shift(coef_e * vbn[i], 16);
    end else begin
      for (int i = 0; i < 3; i++)
        ra[i] = rnd_shift(coef_f * vat[i], 16) - rnd_shift(coef_e * van[i], 16);
    end
    for (int i = 0; i < 3; i++) begin
      r.va[i] = clamp32(ra[i], sat);
      r.vb[i] = clamp32(rb[i], sat);
    end
    r.sat = sat;
    return r;
  endfunction

  function automatic contact_t mk(vel_t ax, vel_t bx, nrm_t nx, nrm_t ny,
                                  logic [31:0] ma, logic [31:0] mb, logic [1:0] frz);
    contact_t c;
    c.va = '{vel_t'(ax >>> 1), vel_t'(-ax), ax};
    c.vb = '{vel_t'(bx >>> 2), bx, bx};
    c.n = '{nrm_t'(0), ny, nx};
    c.ma = ma;
    c.mb = mb;
    c.frz = frz;
    return c;
  endfunction

  function automatic contact_t random_contact();
    contact_t c;
    logic [31:0] t;
    for (int i = 0; i < 3; i++) begin
      t = $urandom;
      c.va[i] = ($urandom_range(0, 2) == 0) ? t : {{9{t[22]}}, t[22:0]};
      t = $urandom;
      c.vb[i] = ($urandom_range(0, 2) == 0) ? t : {{9{t[22]}}, t[22:0]};
      t = $urandom;
      c.n[i] = ($urandom_range(0, 4) == 0) ? t[15:0] : nrm_t'($urandom_range(0, 32768) - 16384);
    end
    c.ma = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(1, 1 << 20);
    c.mb = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(1, 1 << 20);
    c.frz = 2'($urandom_range(0, 3));
    return c;
  endfunction

  task automatic reg_write(input logic idx, input logic [CW-1:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= 32'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_RESTITUTION) coef_e = val;
    else coef_f = val;
  endtask

  task automatic drain();
    while (pending_responses.size() != 0) @(posedge clk_i);
    repeat (32) @(posedge clk_i);
  endtask

  task automatic send_request(contact_t c, bit pass_thru);
    int gap;
    logic took;
    response_t r;
    gap = $urandom_range(0, tx_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    va_d <= c.va;
    vb_d <= c.vb;
    n_d <= c.n;
    ma_d <= c.ma;
    mb_d <= c.mb;
    frz_d <= c.frz;
    do begin
      @(negedge clk_i);
      took = in_ready_o;
      @(posedge clk_i);
    end while (!took);
    if (pass_thru) begin
      r.va = c.va;
      r.vb = c.vb;
      r.sep = 1'b1;
      r.sat = 1'b0;
    end else begin
      r = resolve_contact(c);
    end
    pending_responses.push_back(r);
    n_req++;
  endtask

  // result side: random stalls plus one long hold-off
  initial begin
    int gap;
    logic took;
    response_t got, want;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (rx_hold > 0) begin
        out_ready_i <= 1'b0;
        repeat (rx_hold) @(posedge clk_i);
        rx_hold = 0;
      end
      gap = $urandom_range(0, rx_max);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do begin
        @(negedge clk_i);
        took = out_valid_o;
        got.va = va_q;
        got.vb = vb_q;
        got.sep = sep_q;
        got.sat = sat_q;
        @(posedge clk_i);
      end while (!took);
      n_resp++;
      if (pending_responses.size() == 0) begin
        $display("%0t: unexpected response", $realtime);
        errors++;
      end else begin
        want = pending_responses.pop_front();
        n_sep += want.sep;
        n_sat += want.sat;
        for (int i = 0; i < 3; i++) begin
          if (got.va[i] !== want.va[i]) begin
            $display("%0t: new_vel_a[%0d] exp %0d got %0d", $realtime, i, want.va[i], got.va[i]);
            errors++;
          end
          if (got.vb[i] !== want.vb[i]) begin
            $display("%0t: new_vel_b[%0d] exp %0d got %0d", $realtime, i, want.vb[i], got.vb[i]);
            errors++;
          end
        end
        if (got.sep !== want.sep) begin
          $display("%0t: separating exp %0b got %0b", $realtime, want.sep, got.sep);
          errors++;
        end
        if (got.sat !== want.sat) begin
          $display("%0t: saturated exp %0b got %0b", $realtime, want.sat, got.sat);
          errors++;
        end
      end
    end
  end

  initial begin
    row_t rows[$];
    logic [CW-1:0] e_set[5], f_set[5];
    vel_t vmax, vmin;
    int waited;
    vmax = 32'sh7fffffff;
    vmin = 32'sh80000000;
    e_set = '{17'd0, 17'd65536, 17'd131071, 17'd0, 17'd0};
    f_set = '{17'd0, 17'd65536, 17'd131071, 17'd0, 17'd0};
    errors = 0; n_req = 0; n_resp = 0; n_sep = 0; n_sat = 0; cycles = 0;
    tx_max = 19; rx_max = 19; rx_hold = 0;
    coef_e = RESTITUTION_RST;
    coef_f = TANGENT_KEEP_RST;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    va_d = '0; vb_d = '0; n_d = '0; ma_d = '0; mb_d = '0; frz_d = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // separating pairs pass through unchanged, the other rows are checked against resolve_contact
    rows.push_back('{mk(32'sd65536, -32'sd65536, 16384, 0, 65536, 65536, 2'd0), 1'b1});
    rows.push_back('{mk(vmax, vmin, 16384, 0, 1, 1, 2'd3), 1'b1});
    rows.push_back('{mk(vmin, vmax, -16384, 0, 32'hffffffff, 1, 2'd1), 1'b1});
    rows.push_back('{mk(32'sd0, 32'sd0, 16384, 0, 1, 1, 2'd0), 1'b0});
    for (int m = 0; m < 4; m++) begin
      rows.push_back('{mk(-32'sd131072, 32'sd65536, 16384, 0, 65536, 131072, 2'(m)), 1'b0});
      rows.push_back('{mk(-32'sd98304, 32'sd32768, 11585, 11585, 65536, 65536, 2'(m)), 1'b0});
    end
    rows.push_back('{mk(vmin, vmax, 16384, 0, 1, 1, 2'd0), 1'b0});
    rows.push_back('{mk(vmin, vmax, 16384, -16384, 32'hffffffff, 32'hffffffff, 2'd0), 1'b0});
    rows.push_back('{mk(vmin, vmax, 32767, 32767, 1, 32'hffffffff, 2'd0), 1'b0});
    rows.push_back('{mk(vmax, vmin, -32768, -32768, 32'hffffffff, 1, 2'd2), 1'b0});
    rows.push_back('{mk(vmin, vmax, 16384, 16384, 0, 0, 2'd0), 1'b0});
    rows.push_back('{mk(-32'sd65536, 32'sd0, 16384, 0, 0, 0, 2'd0), 1'b0});
    rows.push_back('{mk(vmin, vmax, -16384, 16384, 5, 7, 2'd1), 1'b0});
    rows.push_back('{mk(vmax, vmin, -32768, 0, 3, 3, 2'd3), 1'b0});
    foreach (rows[i]) send_request(rows[i].c, rows[i].pass_thru);
    in_valid_i <= 1'b0;
    drain();

    e_set[3] = CW'($urandom_range(0, 131071));
    f_set[3] = CW'($urandom_range(0, 131071));
    e_set[4] = RESTITUTION_RST;
    f_set[4] = TANGENT_KEEP_RST;
    for (int ph = 0; ph < 6; ph++) begin
      if (ph < 5) begin
        reg_write(REG_RESTITUTION, e_set[ph]);
        reg_write(REG_TANGENT_KEEP, f_set[ph]);
      end
      tx_max = (ph % 2 == 0) ? 19 : 0;
      rx_max = (ph == 1 || ph == 4) ? 0 : 19;
      if (ph == 2) begin
        rx_hold = 400;
        tx_max = 0;
        rx_max = 0;
      end
      for (int j = 0; j < 250; j++) begin
        if (ph == 2 && j == 120) tx_max = 19;
        send_request(random_contact(), 1'b0);
      end
      in_valid_i <= 1'b0;
      drain();
    end

    waited = 0;
    while (pending_responses.size() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (40) @(posedge clk_i);
    $display("%0d requests, %0d responses (%0d separating, %0d clamped), %0d errors",
             n_req, n_resp, n_sep, n_sat, errors);
    $display("coefficient settings covered zero, one, maximum, random and reset values");
    if (errors == 0 && pending_responses.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
